[hdl/tama_pkg.sv]
// ============================================================================
// tama_pkg
// Shared types and constants for the three-axis moving average unit.
// ============================================================================
package tama_pkg;

    localparam int AXES = 3;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctrl;

endpackage

[hdl/three_axis_moving_average_unit.sv]
// One transaction at a time: a new sample is taken only in the idle state, after the
// previous result has been loaded into the output register. The division runs in the
// bit-serial dividers, which produce one quotient bit per cycle.
// A new sample is accepted while the previous result still waits on the output.
// Reset clears the running sums, the fill count and the ring pointer; the sample ring
// itself is not cleared.
// ============================================================================
// three_axis_moving_average_unit
// Boxcar moving average over the last WINDOW samples of three signed axes.
// ============================================================================
module three_axis_moving_average_unit #(
    parameter int  WINDOW      = 20,
    parameter int  SAMPLE_BITS = 16,
    localparam int TDATA_W     = ((tama_pkg::AXES * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // Fields from bit 0 up: rate_x, rate_y, rate_z, zero padding.
    input  logic [TDATA_W-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // Fields from bit 0 up: mean_x, mean_y, mean_z, zero padding.
    output logic [TDATA_W-1:0] m_axis_tdata
);
    import tama_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int SW  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DVW = $clog2(WINDOW + 1);
    localparam int SLW = $clog2(WINDOW);
    localparam int CW  = $clog2(SW + 1);
    localparam int PW  = AXES * SAMPLE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_step;
    logic [PW-1:0]         r_in;
    logic signed [SW-1:0]  r_sum [AXES];
    logic [SLW-1:0]        r_slot;
    logic [DVW-1:0]        r_fill;
    logic                  r_out_valid;
    logic [PW-1:0]         r_out;

    logic signed [SW-1:0]  n_sum [AXES];
    logic                  w_full;
    logic                  w_accept;
    logic [PW-1:0]         w_old;
    logic [PW-1:0]         w_quot;
    t_div_ctrl             w_div_ctrl;

    assign w_full        = (r_fill == DVW'(WINDOW));
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out);

    assign w_div_ctrl.start = (r_state == S_START);
    assign w_div_ctrl.step  = (r_state == S_DIV);

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a] + SW'($signed(r_in[a*SB +: SB]))
                     - (w_full ? SW'($signed(w_old[a*SB +: SB])) : SW'(0));
        end
    end

    tama_history #(
        .DEPTH (WINDOW),
        .WIDTH (PW)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_UPDATE),
        .i_wr_addr (r_slot),
        .i_wr_data (r_in),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_slot),
        .o_rd_data (w_old)
    );

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        tama_div_lane #(
            .DIVIDEND_W (SW),
            .DIVISOR_W  (DVW),
            .OUT_W      (SB)
        ) u_lane (
            .i_clk      (i_clk),
            .i_ctrl     (w_div_ctrl),
            .i_dividend (r_sum[g]),
            .i_divisor  (r_fill),
            .o_quot     (w_quot[g*SB +: SB])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in    <= s_axis_tdata[PW-1:0];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    for (int a = 0; a < AXES; a++) begin
                        r_sum[a] <= n_sum[a];
                    end
                    r_slot <= (r_slot == SLW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    if (!w_full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_START;
                end
                S_START: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == CW'(SW - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= w_quot;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DVW'(WINDOW))
        else $error("fill count exceeds window");

    a_full_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |=> w_full)
        else $error("ring left the full condition");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_READ)
        else $error("accepted transaction did not start a ring read");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_step < CW'(SW))
        else $error("divider step count out of range");

    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == CW'(SW - 1)) |=> r_state == S_DONE)
        else $error("division did not finish after the last step");

endmodule

[hdl/tama_history.sv]
// ============================================================================
// tama_history
// Sample ring storage: one write port and one registered read port.
// ============================================================================
module tama_history #(
    parameter int DEPTH  = 20,
    parameter int WIDTH  = 48,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/tama_div_lane.sv]
// ============================================================================
// tama_div_lane
// Bit-serial restoring divider for one axis, one quotient bit per cycle,
// with the quotient truncated toward zero.
// ============================================================================
module tama_div_lane #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 5,
    parameter int OUT_W      = 16
) (
    input  logic                         i_clk,
    input  tama_pkg::t_div_ctrl          i_ctrl,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]         i_divisor,
    output logic signed [OUT_W-1:0]      o_quot
);
    import tama_pkg::*;

    logic                  r_neg;
    logic [DIVIDEND_W-1:0] r_dq;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVIDEND_W-1:0] w_mag;
    logic [DIVISOR_W:0]    w_shifted;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;
    logic [DIVIDEND_W-1:0] w_signed_q;

    always_comb begin
        w_mag      = i_dividend[DIVIDEND_W-1] ? (~i_dividend + 1'b1) : i_dividend;
        w_shifted  = {r_rem, r_dq[DIVIDEND_W-1]};
        w_diff     = w_shifted - {1'b0, r_dvs};
        w_ge       = (w_shifted >= {1'b0, r_dvs});
        w_signed_q = r_neg ? (~r_dq + 1'b1) : r_dq;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_neg <= i_dividend[DIVIDEND_W-1];
            r_dq  <= w_mag;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (i_ctrl.step) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shifted[DIVISOR_W-1:0];
            r_dq  <= {r_dq[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_quot = w_signed_q[OUT_W-1:0];

endmodule

[verif/tama_mean_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// tama_mean_checker
// Watches both streams of the moving average unit. It keeps its own sample
// rings, running sums and fill count, works out the three means for every
// accepted sample, and compares them with each result transaction in order.
// ============================================================================
module tama_mean_checker #(
    parameter int  WINDOW      = 20,
    parameter int  SAMPLE_BITS = 16,
    localparam int TDATA_W     = ((tama_pkg::AXES * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    // Fields from bit 0 up: rate_x, rate_y, rate_z, zero padding.
    input  logic [TDATA_W-1:0] i_s_tdata,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    // Fields from bit 0 up: mean_x, mean_y, mean_z, zero padding.
    input  logic [TDATA_W-1:0] i_m_tdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tama_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SLOT_W = $clog2(WINDOW);

    typedef logic signed [SAMPLE_BITS-1:0] t_rate;

    t_rate                   ring [AXES][WINDOW];
    logic signed [SUM_W-1:0] sums [AXES];
    logic [SLOT_W-1:0]       slot;
    logic [FILL_W-1:0]       fill;
    logic [TDATA_W-1:0]      means_due [$];
    string                   axis_field [AXES] = '{"mean_x", "mean_y", "mean_z"};

    function automatic logic [TDATA_W-1:0] advance_window(input logic [TDATA_W-1:0] rates);
        logic [TDATA_W-1:0] means;
        logic               full;
        t_rate              sample;
        means = '0;
        full  = (fill == WINDOW);
        for (int a = 0; a < AXES; a++) begin
            sample = rates[a*SAMPLE_BITS +: SAMPLE_BITS];
            if (full) begin
                sums[a] = sums[a] - ring[a][slot];
            end
            ring[a][slot] = sample;
            sums[a]       = sums[a] + sample;
        end
        slot = (slot == WINDOW - 1) ? '0 : slot + 1'b1;
        if (!full) begin
            fill = fill + 1'b1;
        end
        for (int a = 0; a < AXES; a++) begin
            means[a*SAMPLE_BITS +: SAMPLE_BITS] =
                SAMPLE_BITS'(longint'(sums[a]) / longint'(fill));
        end
        return means;
    endfunction

    always @(posedge i_clk) begin : watch_streams
        logic [TDATA_W-1:0] due;
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                sums[a] = '0;
            end
            slot = '0;
            fill = '0;
            means_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                means_due = {means_due, advance_window(i_s_tdata)};
            end
            if (i_m_tvalid && i_m_tready) begin
                if (means_due.size() == 0) begin
                    $error("result transaction with no sample outstanding: %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    due = means_due.pop_front();
                    for (int a = 0; a < AXES; a++) begin
                        if (i_m_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]
                                !== due[a*SAMPLE_BITS +: SAMPLE_BITS]) begin
                            $error("%s: expected %0d, got %0d", axis_field[a],
                                   $signed(due[a*SAMPLE_BITS +: SAMPLE_BITS]),
                                   $signed(i_m_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]));
                            o_fail_count++;
                        end
                    end
                end
            end
        end
        o_pending = means_due.size();
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives three-axis rate samples into the moving average unit: a warm-up
// with full-scale values, a wrap of the ring, then random bursts of uniform,
// extreme, small and constant values under changing back-pressure. The
// checker beside the unit predicts every mean and counts mismatches.
// ============================================================================
module tb_top;
    import tama_pkg::*;

    localparam int WINDOW       = 20;
    localparam int SAMPLE_BITS  = 16;
    localparam int TDATA_W      = ((AXES * SAMPLE_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * (SAMPLE_BITS + $clog2(WINDOW) + 5);

    typedef logic signed [SAMPLE_BITS-1:0] t_rate;
    typedef enum int {PICK_UNIFORM, PICK_EXTREME, PICK_SMALL, PICK_HOLD} t_pick;

    localparam t_rate RATE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam t_rate RATE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    int                 fail_count;
    int                 pending;
    int                 tx_gap_pct    = 0;
    int                 rx_stall_pct  = 0;

    three_axis_moving_average_unit #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tama_mean_checker #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mean_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: errors");
        $finish;
    end

    function automatic t_rate pick_rate(input t_pick pick, input t_rate held);
        case (pick)
            PICK_EXTREME: pick_rate = $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
            PICK_SMALL:   pick_rate = t_rate'(int'($urandom_range(0, 8)) - 4);
            PICK_HOLD:    pick_rate = held;
            default:      pick_rate = t_rate'($urandom);
        endcase
    endfunction

    task automatic send_rates(input t_rate rate_x, input t_rate rate_y, input t_rate rate_z);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            repeat ($urandom_range(1, 30)) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({rate_z, rate_y, rate_x});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_for_means();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int    sent;
        int    burst;
        bit    paused;
        t_pick pick;
        t_rate held [AXES];
        paused = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_gap_pct   = 15;
        rx_stall_pct = 61;
        // Warm-up at full scale; the z axis exercises truncation of negative sums.
        for (int i = 0; i < WINDOW; i++) begin
            send_rates(RATE_MAX, RATE_MIN, (i % 2 == 0) ? t_rate'(-1) : t_rate'(0));
        end
        // Once full, the oldest full-scale samples are replaced by the opposite extreme.
        for (int i = 0; i < 5; i++) begin
            send_rates(RATE_MIN, RATE_MAX, RATE_MAX);
        end

        for (int phase = 0; phase < 3; phase++) begin
            tx_gap_pct   = (phase == 0) ? 15 : (phase == 1) ? 61 : 0;
            rx_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 15 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                pick  = $urandom_range(0, 1) ? PICK_UNIFORM : t_pick'($urandom_range(1, 3));
                burst = $urandom_range(1, 40);
                for (int a = 0; a < AXES; a++) begin
                    held[a] = pick_rate($urandom_range(0, 1) ? PICK_EXTREME : PICK_UNIFORM, '0);
                end
                for (int i = 0; i < burst; i++) begin
                    send_rates(pick_rate(pick, held[0]), pick_rate(pick, held[1]),
                               pick_rate(pick, held[2]));
                    sent++;
                end
                if (phase == 1 && !paused && sent >= RANDOM_ITEMS / 6) begin
                    wait_for_means();
                    paused = 1'b1;
                end
            end
        end

        wait_for_means();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[files.f]
hdl/tama_pkg.sv
hdl/tama_history.sv
hdl/tama_div_lane.sv
hdl/three_axis_moving_average_unit.sv
verif/tama_mean_checker.sv
verif/tb_top.sv
